// ----- design/ihex_pkg.sv -----
package ihex_pkg;

    // Default flash page size in bytes
    localparam int PAGE_BYTES_DEF = 128;

    // Record start character
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Record type that marks end of file
    localparam logic [7:0] REC_TYPE_EOF = 8'h01;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_WAIT = 7'b0000001,
        PH_LEN  = 7'b0000010,
        PH_ADDR = 7'b0000100,
        PH_TYPE = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_SUM  = 7'b0100000,
        PH_ERR  = 7'b1000000
    } phase_t;

    // One result beat
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic [6:0]  byte_index;
        logic        page_commit;
        logic [15:0] page_address;
        logic        record_done;
        logic        checksum_ok;
        logic        end_of_file;
        logic        parse_error;
    } result_t;

    // ASCII hex digit to nibble; anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [3:0] val;
        val = 4'h0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            val = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            val = 4'(ch - 8'h37);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            val = 4'(ch - 8'h57);
        end
        return val;
    endfunction

endpackage

// ----- design/intel_hex_record_parser_core.sv -----
// Characters are registered on input and result beats in the result register.
// Throughput: one character per cycle unless a held result beat stalls the input.
// Page base alignment runs in a registered multiply pipeline off the address field;
// a commit needs it no sooner than four characters later.
// Reset: synchronous, active low; parser returns to waiting for ':' with an empty page.
module intel_hex_record_parser_core #(
    parameter int PAGE_BYTES = ihex_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ascii_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_byte_valid,
    output logic [7:0]  m_data_byte,
    output logic [6:0]  m_byte_index,
    output logic        m_page_commit,
    output logic [15:0] m_page_address,
    output logic        m_record_done,
    output logic        m_checksum_ok,
    output logic        m_end_of_file,
    output logic        m_parse_error
);
    import ihex_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_free;
    logic        fire;
    logic        emit;
    result_t     result;
    logic        addr_capture;
    logic [15:0] addr_value;
    logic [15:0] page_base;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || fire;

    // Input character register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            char_reg <= s_ascii_char;
        end
    end

    ihex_parse #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .ascii_char   (char_reg),
        .page_base    (page_base),
        .addr_capture (addr_capture),
        .addr_value   (addr_value),
        .emit         (emit),
        .result       (result)
    );

    ihex_page_base #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_base (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capture   (addr_capture),
        .address   (addr_value),
        .page_base (page_base)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && emit;
        end
        if (fire && emit) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_data_byte    = out_reg.data_byte;
    assign m_byte_index   = out_reg.byte_index;
    assign m_page_commit  = out_reg.page_commit;
    assign m_page_address = out_reg.page_address;
    assign m_record_done  = out_reg.record_done;
    assign m_checksum_ok  = out_reg.checksum_ok;
    assign m_end_of_file  = out_reg.end_of_file;
    assign m_parse_error  = out_reg.parse_error;

endmodule

// ----- design/ihex_page_base.sv -----
module ihex_page_base #(
    parameter int PAGE_BYTES = ihex_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        capture,
    input  logic [15:0] address,
    output logic [15:0] page_base
);
    import ihex_pkg::*;

    // Exact 16-bit division by a constant: floor(a * RECIP >> SHIFT)
    localparam int          LOG_P   = $clog2(PAGE_BYTES);
    localparam int          SHIFT   = 16 + LOG_P;
    localparam logic [16:0] RECIP   = 17'(((64'd1 << SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES);
    localparam logic [8:0]  PAGE_SZ = 9'(PAGE_BYTES);

    logic        cap_valid_reg;
    logic [15:0] addr_reg;
    logic        quot_valid_reg;
    logic [15:0] quot_reg;
    logic [15:0] page_base_reg;
    logic [32:0] quot_prod;
    logic [24:0] base_prod;

    assign quot_prod = {16'b0, addr_reg} * {16'b0, RECIP};
    assign base_prod = {9'b0, quot_reg} * {16'b0, PAGE_SZ};

    // Address capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_valid_reg <= 1'b0;
        end else begin
            cap_valid_reg <= capture;
        end
        if (capture) begin
            addr_reg <= address;
        end
    end

    // Quotient stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_valid_reg <= 1'b0;
        end else begin
            quot_valid_reg <= cap_valid_reg;
        end
        if (cap_valid_reg) begin
            quot_reg <= 16'(quot_prod >> SHIFT);
        end
    end

    // Aligned base: quotient times page size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_base_reg <= '0;
        end else if (quot_valid_reg) begin
            page_base_reg <= base_prod[15:0];
        end
    end

    assign page_base = page_base_reg;

endmodule

// ----- design/ihex_parse.sv -----
module ihex_parse #(
    parameter int PAGE_BYTES = ihex_pkg::PAGE_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        ascii_char,
    input  logic [15:0]       page_base,
    output logic              addr_capture,
    output logic [15:0]       addr_value,
    output logic              emit,
    output ihex_pkg::result_t result
);
    import ihex_pkg::*;

    localparam int FILL_W = $clog2(PAGE_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(PAGE_BYTES - 1);

    phase_t            phase_reg,   phase_next;
    logic [2:0]        count_reg,   count_next;
    logic [15:0]       acc_reg,     acc_next;
    logic [7:0]        len_reg,     len_next;
    logic [7:0]        type_reg,    type_next;
    logic [7:0]        sum_reg,     sum_next;
    logic [7:0]        bytes_reg,   bytes_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic              need_reg,    need_next;

    logic [15:0] acc_shift;
    logic [2:0]  count_inc;
    logic [7:0]  low_byte;
    logic [7:0]  sum_total;
    logic [7:0]  bytes_inc;
    logic [7:0]  fill_ext;
    logic        pair_done;
    logic        quad_done;
    logic        capture;

    assign acc_shift = {acc_reg[11:0], hex_value(ascii_char)};
    assign count_inc = count_reg + 3'd1;
    assign pair_done = (count_inc >= 3'd2);
    assign quad_done = (count_inc >= 3'd4);
    assign low_byte  = acc_shift[7:0];
    assign sum_total = sum_reg + low_byte;
    assign bytes_inc = bytes_reg + 8'd1;
    assign fill_ext  = 8'(fill_reg);

    // Next state and result for the character at hand
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        sum_next   = sum_reg;
        bytes_next = bytes_reg;
        fill_next  = fill_reg;
        need_next  = need_reg;
        capture    = 1'b0;
        emit       = 1'b0;
        result     = '0;

        unique case (phase_reg)
            PH_WAIT: begin
                if (ascii_char == CHAR_COLON) begin
                    phase_next = PH_LEN;
                    count_next = '0;
                    acc_next   = '0;
                    sum_next   = '0;
                end
            end
            PH_LEN: begin
                acc_next = acc_shift;
                if (pair_done) begin
                    count_next = '0;
                    len_next   = low_byte;
                    sum_next   = sum_total;
                    phase_next = PH_ADDR;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_ADDR: begin
                acc_next = acc_shift;
                if (quad_done) begin
                    count_next = '0;
                    sum_next   = sum_reg + acc_shift[7:0] + acc_shift[15:8];
                    if (need_reg) begin
                        capture   = 1'b1;
                        need_next = 1'b0;
                    end
                    phase_next = PH_TYPE;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_TYPE: begin
                acc_next = acc_shift;
                if (pair_done) begin
                    count_next = '0;
                    type_next  = low_byte;
                    sum_next   = sum_total;
                    bytes_next = '0;
                    // end of file and empty records skip the data digits
                    if (low_byte == REC_TYPE_EOF || len_reg == 8'd0) begin
                        phase_next = PH_SUM;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            PH_DATA: begin
                acc_next = acc_shift;
                if (pair_done) begin
                    count_next        = '0;
                    sum_next          = sum_total;
                    emit              = 1'b1;
                    result.byte_valid = 1'b1;
                    result.data_byte  = low_byte;
                    result.byte_index = fill_ext[6:0];
                    bytes_next        = bytes_inc;
                    if (bytes_inc == len_reg) begin
                        phase_next = PH_SUM;
                    end
                    // full page: commit and start over
                    if (fill_reg == FILL_LAST) begin
                        result.page_commit  = 1'b1;
                        result.page_address = page_base;
                        fill_next           = '0;
                        need_next           = 1'b1;
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            PH_SUM: begin
                acc_next = acc_shift;
                if (pair_done) begin
                    count_next         = '0;
                    sum_next           = sum_total;
                    emit               = 1'b1;
                    result.record_done = 1'b1;
                    result.checksum_ok = (sum_total == 8'd0);
                    phase_next         = (sum_total == 8'd0) ? PH_WAIT : PH_ERR;
                    // end of file commits the partial page regardless of checksum
                    if (type_reg == REC_TYPE_EOF) begin
                        result.page_commit  = 1'b1;
                        result.page_address = page_base;
                        result.end_of_file  = 1'b1;
                        fill_next           = '0;
                        need_next           = 1'b1;
                    end
                end else begin
                    count_next = count_inc;
                end
            end
            default: begin
                // error state: sticky until reset
                emit               = 1'b1;
                result.parse_error = 1'b1;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            count_reg <= '0;
            acc_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            sum_reg   <= '0;
            bytes_reg <= '0;
            fill_reg  <= '0;
            need_reg  <= 1'b1;
        end else if (fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            sum_reg   <= sum_next;
            bytes_reg <= bytes_next;
            fill_reg  <= fill_next;
            need_reg  <= need_next;
        end
    end

    assign addr_capture = fire && capture;
    assign addr_value   = acc_shift;

endmodule

// ----- test/tb_intel_hex_record_parser_core.sv -----
module tb_intel_hex_record_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int PAGE        = PAGE_BYTES_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 270;

    // Parser state as the predictor tracks it
    typedef struct {
        phase_t      ph;
        logic [2:0]  dcount;
        logic [15:0] acc;
        logic [7:0]  rec_len;
        logic [7:0]  rec_type;
        logic [7:0]  sum;
        logic [7:0]  rec_bytes;
        logic [15:0] base;
        logic [7:0]  fill;
        logic        fresh_page;
    } parser_state_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ascii_char = 8'h00;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_byte_valid;
    logic [7:0]  m_data_byte;
    logic [6:0]  m_byte_index;
    logic        m_page_commit;
    logic [15:0] m_page_address;
    logic        m_record_done;
    logic        m_checksum_ok;
    logic        m_end_of_file;
    logic        m_parse_error;

    logic [7:0]    hex_stream[$];
    result_t       predicted_beats[$];
    parser_state_t rx_model;
    parser_state_t tx_model;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            live_items     = 0;
    int            bad_beats      = 0;
    int            beats_seen     = 0;
    int            quiet_cycles   = 0;

    intel_hex_record_parser_core #(.PAGE_BYTES(PAGE)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ascii_char  (s_ascii_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_valid  (m_byte_valid),
        .m_data_byte   (m_data_byte),
        .m_byte_index  (m_byte_index),
        .m_page_commit (m_page_commit),
        .m_page_address(m_page_address),
        .m_record_done (m_record_done),
        .m_checksum_ok (m_checksum_ok),
        .m_end_of_file (m_end_of_file),
        .m_parse_error (m_parse_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic parser_state_t parser_idle();
        parser_state_t st;
        st.ph         = PH_WAIT;
        st.dcount     = '0;
        st.acc        = '0;
        st.rec_len    = '0;
        st.rec_type   = '0;
        st.sum        = '0;
        st.rec_bytes  = '0;
        st.base       = '0;
        st.fill       = '0;
        st.fresh_page = 1'b1;
        return st;
    endfunction

    // Hex digit value; any other character reads as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] ch);
        if (ch inside {["0":"9"]}) begin
            return 4'(ch - "0");
        end
        if (ch inside {["A":"F"]}) begin
            return 4'(ch - "A" + 10);
        end
        if (ch inside {["a":"f"]}) begin
            return 4'(ch - "a" + 10);
        end
        return 4'h0;
    endfunction

    // Shift one digit in; true once the field has all its digits
    function automatic bit shift_digit(inout parser_state_t st, input logic [7:0] ch,
                                       input int need);
        st.acc    = {st.acc[11:0], nibble_of(ch)};
        st.dcount = st.dcount + 3'd1;
        if (int'(st.dcount) >= need) begin
            st.dcount = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the parser by one character; true when it yields a result beat
    function automatic bit parse_char(inout parser_state_t st, input logic [7:0] ch,
                                      output result_t res);
        logic [7:0] b;
        bit         got;
        res = '0;
        got = 1'b0;
        case (st.ph)
            PH_WAIT: begin
                if (ch == CHAR_COLON) begin
                    st.ph     = PH_LEN;
                    st.dcount = '0;
                    st.acc    = '0;
                    st.sum    = '0;
                end
            end
            PH_LEN: begin
                if (shift_digit(st, ch, 2)) begin
                    st.rec_len = st.acc[7:0];
                    st.sum     = st.sum + st.rec_len;
                    st.ph      = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (shift_digit(st, ch, 4)) begin
                    st.sum = st.sum + st.acc[7:0] + st.acc[15:8];
                    // first record of a page fixes its aligned base
                    if (st.fresh_page) begin
                        st.base       = st.acc - 16'(st.acc % PAGE);
                        st.fresh_page = 1'b0;
                    end
                    st.ph = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (shift_digit(st, ch, 2)) begin
                    st.rec_type  = st.acc[7:0];
                    st.sum       = st.sum + st.rec_type;
                    st.rec_bytes = '0;
                    st.ph = (st.rec_type == REC_TYPE_EOF || st.rec_len == 8'd0) ?
                            PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                if (shift_digit(st, ch, 2)) begin
                    b              = st.acc[7:0];
                    st.sum         = st.sum + b;
                    got            = 1'b1;
                    res.byte_valid = 1'b1;
                    res.data_byte  = b;
                    res.byte_index = st.fill[6:0];
                    st.rec_bytes   = st.rec_bytes + 8'd1;
                    if (st.rec_bytes == st.rec_len) begin
                        st.ph = PH_SUM;
                    end
                    // full page goes out with its last byte
                    if (int'(st.fill) + 1 >= PAGE) begin
                        res.page_commit  = 1'b1;
                        res.page_address = st.base;
                        st.fill          = '0;
                        st.fresh_page    = 1'b1;
                    end else begin
                        st.fill = st.fill + 8'd1;
                    end
                end
            end
            PH_SUM: begin
                if (shift_digit(st, ch, 2)) begin
                    st.sum          = st.sum + st.acc[7:0];
                    got             = 1'b1;
                    res.record_done = 1'b1;
                    res.checksum_ok = (st.sum == 8'd0);
                    st.ph           = (st.sum == 8'd0) ? PH_WAIT : PH_ERR;
                    // end of file flushes the page whatever the checksum
                    if (st.rec_type == REC_TYPE_EOF) begin
                        res.page_commit  = 1'b1;
                        res.page_address = st.base;
                        res.end_of_file  = 1'b1;
                        st.fill          = '0;
                        st.fresh_page    = 1'b1;
                    end
                end
            end
            default: begin
                got             = 1'b1;
                res.parse_error = 1'b1;
            end
        endcase
        return got;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'("0" + n);
        end
        return ($urandom_range(1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (nibble_of(c) != 4'h0 || c == "0") begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] data_value();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Queue one character and keep the stream's own parser view in step
    task automatic push_char(input logic [7:0] ch);
        result_t unused;
        if (tx_model.ph != PH_WAIT || ch == CHAR_COLON) begin
            live_items++;
        end
        void'(parse_char(tx_model, ch, unused));
        hex_stream.push_back(ch);
    endtask

    // Two digits; a zero nibble is sometimes sent as a non-hex character
    task automatic push_byte(input logic [7:0] b);
        logic [3:0] nib;
        for (int i = 1; i >= 0; i--) begin
            nib = b[i*4 +: 4];
            if (nib == 4'h0 && $urandom_range(19) == 0) begin
                push_char(non_hex_char());
            end else begin
                push_char(hex_char(nib));
            end
        end
    endtask

    task automatic push_record(input logic [7:0] rtype, input int len,
                               input logic [15:0] addr, input bit corrupt);
        logic [7:0] chk;
        push_char(CHAR_COLON);
        push_byte(8'(len));
        push_byte(addr[15:8]);
        push_byte(addr[7:0]);
        push_byte(rtype);
        while (tx_model.ph == PH_DATA) begin
            push_byte(data_value());
        end
        chk = 8'h00 - tx_model.sum;
        if (corrupt) begin
            chk = chk + 8'($urandom_range(1, 255));
        end
        push_byte(chk);
    endtask

    // Garbage after ':' then padding up to the checksum, which is kept good
    task automatic push_broken_record();
        int n;
        push_char(CHAR_COLON);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n && tx_model.ph != PH_SUM; i++) begin
            push_char(8'($urandom_range(255)));
        end
        while (tx_model.ph != PH_SUM) begin
            push_char(hex_char(4'($urandom_range(15))));
        end
        push_byte(8'h00 - tx_model.sum);
    endtask

    task automatic push_traffic(input int target);
        int         pick;
        logic [7:0] c;
        logic [15:0] addr;
        live_items = 0;
        while (live_items < target) begin
            // line endings and stray characters between records
            repeat ($urandom_range(2)) begin
                case ($urandom_range(3))
                    0:       c = 8'h0D;
                    1:       c = 8'h0A;
                    default: c = 8'($urandom_range(255));
                endcase
                push_char((c == CHAR_COLON) ? 8'h20 : c);
            end
            pick = $urandom_range(99);
            addr = 16'($urandom_range(16'hFFFF));
            if (pick < 62) begin
                push_record(8'h00, $urandom_range(1, 24), addr, 1'b0);
            end else if (pick < 70) begin
                push_record(8'($urandom_range(2, 5)), 2 * $urandom_range(1, 2), addr, 1'b0);
            end else if (pick < 76) begin
                push_record(REC_TYPE_EOF,
                            ($urandom_range(3) == 0) ? $urandom_range(1, 255) : 0,
                            addr, 1'b0);
            end else if (pick < 82) begin
                push_record(8'h00, 0, addr, 1'b0);
            end else if (pick < 87) begin
                push_record(8'($urandom_range(6, 255)), $urandom_range(8), addr, 1'b0);
            end else begin
                push_broken_record();
            end
        end
    endtask

    // Stimulus: directed opening, then four idling mixes
    initial begin
        rx_model = parser_idle();
        tx_model = parser_idle();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            if (p == 0) begin
                push_char(8'h00);
                push_char(8'hFF);
                push_record(8'h00, 0, 16'h0000, 1'b0);
                push_record(REC_TYPE_EOF, 2, 16'hFFFF, 1'b0);
            end
            if (p == 1) begin
                push_record(8'h00, 255, 16'h8000, 1'b0);
            end
            push_traffic(PHASE_ITEMS);
            // bad checksum locks the parser, so it closes the run
            if (p == 3) begin
                push_record(8'h00, $urandom_range(1, 8), 16'($urandom_range(16'hFFFF)), 1'b1);
                repeat (6) push_char(8'($urandom_range(255)));
            end
            while (hex_stream.size() != 0 || s_valid || predicted_beats.size() != 0) begin
                @(negedge aclk);
            end
        end

        repeat (8) @(posedge aclk);
        if (bad_beats == 0 && predicted_beats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Character driver; predicts the result beat as each character is taken
    always @(posedge aclk) begin : drive_chars
        result_t beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (parse_char(rx_model, s_ascii_char, beat)) begin
                    predicted_beats.push_back(beat);
                end
            end
            if (!s_valid || s_ready) begin
                if (hex_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid      <= 1'b1;
                    s_ascii_char <= hex_stream.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin : check_beats
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                got = {m_byte_valid, m_data_byte, m_byte_index, m_page_commit,
                       m_page_address, m_record_done, m_checksum_ok, m_end_of_file,
                       m_parse_error};
                beats_seen++;
                if (predicted_beats.size() == 0) begin
                    bad_beats++;
                    if (bad_beats <= 10) begin
                        $display("beat %0d: unexpected result %p", beats_seen, got);
                    end
                end else begin
                    want = predicted_beats.pop_front();
                    if (got !== want) begin
                        bad_beats++;
                        if (bad_beats <= 10) begin
                            $display("beat %0d mismatch:", beats_seen);
                            $write("    exp bv=%b db=%h bi=%h pc=%b pa=%h",
                                   want.byte_valid, want.data_byte, want.byte_index,
                                   want.page_commit, want.page_address);
                            $display(" rd=%b ok=%b eof=%b pe=%b", want.record_done,
                                     want.checksum_ok, want.end_of_file, want.parse_error);
                            $write("    got bv=%b db=%h bi=%h pc=%b pa=%h",
                                   got.byte_valid, got.data_byte, got.byte_index,
                                   got.page_commit, got.page_address);
                            $display(" rd=%b ok=%b eof=%b pe=%b", got.record_done,
                                     got.checksum_ok, got.end_of_file, got.parse_error);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
